/* src/dhb_pkg.sv */
// Package for the decimating history buffer.
// Request and result types and fixed codes; no dependencies.
`default_nettype none
package dhb_pkg;

    localparam logic       FUNC_PUSH    = 1'b0;
    localparam logic       FUNC_READ    = 1'b1;
    localparam logic [4:0] MAX_EXPONENT = 5'd30;

    typedef struct packed {
        logic               func;
        logic signed [31:0] score;
        logic        [7:0]  read_index;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic        [8:0]  entry_count;
        logic        [4:0]  step_exponent;
        logic        [31:0] iteration_count;
        logic               sample_stored;
        logic               recording_stopped;
    } t_rsp;

endpackage
`default_nettype wire

/* src/decimating_history_buffer.sv */
// Decimating history buffer top level; uses dhb_pkg and dhb_ram.
// A push gives its result in the cycle after acceptance and busy stays low;
// a read passes through S_READ, where the registered RAM data is taken, before its result.
// A push that fills the store starts an in-place compaction through the single
// RAM read port, with busy high through S_COMPACT and S_DRAIN until its result.
// Reset clears counters, exponent, halt flag and the sentinel register; the
// store itself is not cleared. The receiver cannot stall: results are strobed.
`default_nettype none
module decimating_history_buffer #(
    parameter int DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               start,
    output logic                    busy,
    input  wire dhb_pkg::t_req      i_req,
    // sentinel register write
    input  wire logic               i_cfg_we,
    input  wire logic signed [31:0] i_cfg_wdata,
    // result channel
    output logic                    o_valid,
    output dhb_pkg::t_rsp           o_result
);

    // Address, half-store index and counter widths all follow DEPTH.
    localparam int AW   = $clog2(DEPTH);
    localparam int KW   = (AW > 1) ? AW - 1 : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = (CW > 8) ? CW : 8;
    localparam int HALF = DEPTH / 2;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_READ    = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;
    localparam logic [1:0] S_DRAIN   = 2'd3;

    logic [1:0]         r_state, n_state;
    logic signed [31:0] r_unknown;
    logic [CW-1:0]      r_count, n_count;
    logic [30:0]        r_spacing, n_spacing;
    logic [4:0]         r_exp, n_exp;
    logic [31:0]        r_total, n_total;
    logic               r_halted, n_halted;
    logic [KW-1:0]      r_k, n_k;
    logic [KW-1:0]      r_wk, n_wk;
    logic               r_wpend, n_wpend;
    logic               r_in_range, n_in_range;
    logic               r_valid, n_valid;
    dhb_pkg::t_rsp      r_rsp, n_rsp;
    dhb_pkg::t_rsp      r_pend, n_pend;

    logic               accept;
    logic               is_push;
    logic [30:0]        spacing_inc;
    logic [30:0]        threshold;
    logic               take_sample;
    logic [CW-1:0]      count_inc;
    logic               fills;
    logic signed [31:0] sample;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign is_push = (i_req.func == dhb_pkg::FUNC_PUSH);

    // Spacing test: while recording runs, the incremented counter reaching 2^exponent takes a sample.
    assign spacing_inc = r_spacing + 31'd1;
    assign threshold   = 31'd1 << r_exp;
    assign take_sample = !r_halted && (spacing_inc >= threshold);
    assign count_inc   = r_count + CW'(1);
    assign fills       = (count_inc == CW'(DEPTH));
    // The sentinel is matched bit for bit and stored as zero.
    assign sample      = (i_req.score == r_unknown) ? 32'sd0 : i_req.score;

    // RAM ports: in idle the push writes at the fill point and a read request
    // addresses its entry; during compaction read 2k+1 and write it back at k
    // in the next cycle. Reads always run ahead of writes, so no forwarding.
    always_comb begin
        if (r_state == S_IDLE) begin
            ram_we    = accept && is_push && take_sample;
            ram_waddr = AW'(r_count);
            ram_wdata = sample;
            ram_raddr = AW'(i_req.read_index);
        end else begin
            ram_we    = r_wpend;
            ram_waddr = AW'(r_wk);
            ram_wdata = ram_rdata;
            ram_raddr = AW'({r_k, 1'b1});
        end
    end

    dhb_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_spacing  = r_spacing;
        n_exp      = r_exp;
        n_total    = r_total;
        n_halted   = r_halted;
        n_k        = r_k;
        n_wk       = r_wk;
        n_wpend    = 1'b0;
        n_in_range = r_in_range;
        n_valid    = 1'b0;
        n_rsp      = r_rsp;
        n_pend     = r_pend;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_push) begin
                        n_total = r_total + 32'd1;
                        if (!r_halted) begin
                            n_spacing = spacing_inc;
                        end
                        if (take_sample) begin
                            n_spacing = 31'd0;
                            n_count   = count_inc;
                            if (fills) begin
                                // Store full: halve it and widen the spacing, or stop recording at the top exponent.
                                n_count = CW'(HALF);
                                if (r_exp >= dhb_pkg::MAX_EXPONENT) begin
                                    n_exp    = dhb_pkg::MAX_EXPONENT;
                                    n_halted = 1'b1;
                                end else begin
                                    n_exp = r_exp + 5'd1;
                                end
                            end
                        end
                        n_pend.read_value        = 32'sd0;
                        n_pend.entry_count       = 9'(n_count);
                        n_pend.step_exponent     = n_exp;
                        n_pend.iteration_count   = n_total;
                        n_pend.sample_stored     = take_sample;
                        n_pend.recording_stopped = n_halted;
                        if (take_sample && fills) begin
                            // Hold the result until the compaction is done.
                            n_k     = '0;
                            n_state = S_COMPACT;
                        end else begin
                            n_valid = 1'b1;
                            n_rsp   = n_pend;
                        end
                    end else begin
                        n_in_range = (IW'(i_req.read_index) < IW'(r_count));
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                n_valid                   = 1'b1;
                n_rsp.read_value          = r_in_range ? ram_rdata : 32'sd0;
                n_rsp.entry_count         = 9'(r_count);
                n_rsp.step_exponent       = r_exp;
                n_rsp.iteration_count     = r_total;
                n_rsp.sample_stored       = 1'b0;
                n_rsp.recording_stopped   = r_halted;
                n_state                   = S_IDLE;
            end
            S_COMPACT: begin
                // Issue read of 2k+1 now; its write-back to k follows next cycle.
                n_wpend = 1'b1;
                n_wk    = r_k;
                if (r_k == KW'(HALF - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_DRAIN: begin
                n_valid = 1'b1;
                n_rsp   = r_pend;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_unknown <= 32'sd0;
            r_count   <= '0;
            r_spacing <= '0;
            r_exp     <= '0;
            r_total   <= '0;
            r_halted  <= 1'b0;
            r_k       <= '0;
            r_wpend   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_unknown <= i_cfg_wdata;
            end
            r_count   <= n_count;
            r_spacing <= n_spacing;
            r_exp     <= n_exp;
            r_total   <= n_total;
            r_halted  <= n_halted;
            r_k       <= n_k;
            r_wpend   <= n_wpend;
            r_valid   <= n_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_wk       <= n_wk;
        r_in_range <= n_in_range;
        r_rsp      <= n_rsp;
        r_pend     <= n_pend;
    end

    assign o_valid  = r_valid;
    assign o_result = r_rsp;

    // Between requests the store is never left full.
    a_count_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count < CW'(DEPTH)))
        else $error("entry count reached DEPTH outside compaction");

    // Recording only stops at the top exponent.
    a_halt_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_exp == dhb_pkg::MAX_EXPONENT))
        else $error("halted below the maximum exponent");

    // A read request answers once it has passed S_READ and the result register.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_push) |=> ##1 o_valid)
        else $error("read result missing");

    // A compaction write-back never collides with an accepted request.
    a_no_accept_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> !accept)
        else $error("request accepted during compaction");

endmodule
`default_nettype wire

/* src/dhb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module dhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* tb/sv/decimating_history_buffer_test.sv */
// Self-checking test of the decimating history buffer: random and directed
// push/read requests, sentinel changes, and a result check against a local predictor.
// Depends on dhb_pkg and the decimating_history_buffer RTL.
`default_nettype none
module decimating_history_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 256;
    // Slowest run is roughly 560 requests, each at the longest idle gap, plus
    // a few compactions; allow several times that.
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // Track the trace store and its counters, and hold the results that the
    // block still owes, oldest first.
    class history_scoreboard;
        logic [31:0]   sentinel;
        logic [31:0]   trace [DEPTH];
        logic [8:0]    entries;
        logic [30:0]   spacing;
        logic [4:0]    exponent;
        logic [31:0]   pushes;
        logic          halted;
        dhb_pkg::t_rsp owed [$];
        int            errors;

        function new();
            sentinel = '0;
            entries  = '0;
            spacing  = '0;
            exponent = '0;
            pushes   = '0;
            halted   = 1'b0;
            errors   = 0;
            foreach (trace[k]) trace[k] = '0;
        endfunction

        function void set_sentinel(logic [31:0] code);
            sentinel = code;
        endfunction

        // Advance the trace state for one accepted request and queue its result.
        function void note_request(dhb_pkg::t_req req);
            dhb_pkg::t_rsp want;
            want = '0;
            if (req.func == dhb_pkg::FUNC_PUSH) begin
                pushes = pushes + 32'd1;
                if (!halted) begin
                    spacing = spacing + 31'd1;
                    if ({1'b0, spacing} >= (32'd1 << exponent)) begin
                        if (entries < DEPTH)
                            trace[entries] = (req.score == sentinel) ? '0 : req.score;
                        entries = entries + 9'd1;
                        spacing = '0;
                        want.sample_stored = 1'b1;
                        if (entries >= DEPTH) begin
                            for (int k = 0; k < DEPTH / 2; k++)
                                trace[k] = trace[2 * k + 1];
                            entries = 9'(DEPTH / 2);
                            if (exponent >= dhb_pkg::MAX_EXPONENT) begin
                                exponent = dhb_pkg::MAX_EXPONENT;
                                halted   = 1'b1;
                            end else begin
                                exponent = exponent + 5'd1;
                            end
                        end
                    end
                end
            end else if (req.read_index < entries && req.read_index < DEPTH) begin
                want.read_value = trace[req.read_index];
            end
            want.entry_count       = entries;
            want.step_exponent     = exponent;
            want.iteration_count   = pushes;
            want.recording_stopped = halted;
            owed.push_back(want);
        endfunction

        function void check_result(dhb_pkg::t_rsp got);
            dhb_pkg::t_rsp want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: read_value %h count %0d exp %0d iter %0d",
                             got.read_value, got.entry_count, got.step_exponent,
                             got.iteration_count);
                return;
            end
            want = owed.pop_front();
            if (got.read_value !== want.read_value ||
                got.entry_count !== want.entry_count ||
                got.step_exponent !== want.step_exponent ||
                got.iteration_count !== want.iteration_count ||
                got.sample_stored !== want.sample_stored ||
                got.recording_stopped !== want.recording_stopped) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("mismatch: read_value want %h got %h, entry_count want %0d got %0d",
                             want.read_value, got.read_value,
                             want.entry_count, got.entry_count);
                    $display("  step_exponent want %0d got %0d, iteration_count want %0d got %0d",
                             want.step_exponent, got.step_exponent,
                             want.iteration_count, got.iteration_count);
                    $display("  sample_stored want %b got %b, recording_stopped want %b got %b",
                             want.sample_stored, got.sample_stored,
                             want.recording_stopped, got.recording_stopped);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    dhb_pkg::t_req      i_req;
    logic               i_cfg_we;
    logic signed [31:0] i_cfg_wdata;
    logic               o_valid;
    dhb_pkg::t_rsp      o_result;

    history_scoreboard sb = new();

    decimating_history_buffer #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Results are strobed and cannot be held off: check each one at the edge
    // that closes its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_result);
    end

    // Abort a hung run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Raise start with the request and hold it until the block takes it.
    // Leave start high afterwards so back-to-back requests need no second
    // assignment in the same step; callers lower it when they pause.
    task automatic send_request(input dhb_pkg::t_req req);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        sb.note_request(req);
    endtask

    // Idle the sender for a random stretch: mostly none or short, a few long.
    task automatic idle_gap(input bit enabled);
        int pick;
        int len;
        if (!enabled)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = 0;
        else if (pick < 92)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(10, 40);
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Drop start and hold off until every owed result has come back, then let
    // the block settle for a few cycles so it is idle for a register write.
    task automatic drain();
        start <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sentinel(input logic [31:0] code);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        sb.set_sentinel(code);
        i_cfg_we    <= 1'b0;
    endtask

    // One random phase under a fixed sentinel. Pushes dominate so the store
    // fills and compacts; reads mostly land on valid entries, the rest fall
    // anywhere in the index range. Sentinel and extreme scores show up often.
    task automatic run_phase(input logic [31:0] code, input int n_items,
                             input bit idling, input bit mid_drain);
        dhb_pkg::t_req req;
        int            pick;
        drain();
        write_sentinel(code);
        for (int n = 0; n < n_items; n++) begin
            req = '0;
            req.read_index = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                req.func = dhb_pkg::FUNC_PUSH;
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    req.score = sb.sentinel;
                else if (pick < 30)
                    case ($urandom_range(0, 3))
                        0:       req.score = 32'h0000_0000;
                        1:       req.score = 32'h7FFF_FFFF;
                        2:       req.score = 32'h8000_0000;
                        default: req.score = 32'hFFFF_FFFF;
                    endcase
                else
                    req.score = $urandom;
            end else begin
                req.func  = dhb_pkg::FUNC_READ;
                req.score = $urandom;
                if (sb.entries != 0 && $urandom_range(0, 99) < 70)
                    req.read_index = 8'($urandom_range(0, int'(sb.entries) - 1));
            end
            send_request(req);
            if (mid_drain && n == n_items / 2)
                drain();
            else
                idle_gap(idling);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reads of an empty store, the sentinel at its reset value of
        // zero, extreme scores, reads inside and past the count.
        send_request('{dhb_pkg::FUNC_READ, 32'h0000_0000, 8'd0});
        send_request('{dhb_pkg::FUNC_READ, 32'hFFFF_FFFF, 8'd255});
        send_request('{dhb_pkg::FUNC_PUSH, 32'h0000_0000, 8'd0});
        send_request('{dhb_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 8'd0});
        send_request('{dhb_pkg::FUNC_PUSH, 32'h8000_0000, 8'hFF});
        send_request('{dhb_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 8'd0});
        send_request('{dhb_pkg::FUNC_PUSH, 32'h0001_0000, 8'd0});
        for (int k = 0; k <= 5; k++)
            send_request('{dhb_pkg::FUNC_READ, 32'h0000_0000, 8'(k)});
        send_request('{dhb_pkg::FUNC_READ, 32'h0000_0000, 8'd255});

        // Move the sentinel to the most negative code: a matching push must
        // store zero, a zero push stays zero, others pass unchanged.
        drain();
        write_sentinel(32'h8000_0000);
        send_request('{dhb_pkg::FUNC_PUSH, 32'h8000_0000, 8'd0});
        send_request('{dhb_pkg::FUNC_PUSH, 32'h0000_0000, 8'd0});
        send_request('{dhb_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 8'd0});
        send_request('{dhb_pkg::FUNC_READ, 32'h0000_0000, 8'd5});
        send_request('{dhb_pkg::FUNC_READ, 32'h0000_0000, 8'd7});
        send_request('{dhb_pkg::FUNC_READ, 32'h0000_0000, 8'd8});

        // Random phases; the store fills and compacts partway through. The
        // exponent ceiling needs about 2^37 pushes and stays out of reach.
        run_phase(32'h7FFF_FFFF, 90, 1'b1, 1'b0);
        run_phase(32'hFFFF_FFFF, 90, 1'b0, 1'b0);
        run_phase($urandom,      90, 1'b1, 1'b1);
        run_phase(32'h8000_0000, 90, 1'b1, 1'b0);
        run_phase(32'h0000_0000, 90, 1'b1, 1'b0);
        run_phase($urandom,      90, 1'b1, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
